// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: property violated");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`endif

// ----- hw/rtl/bcpf_pkg.sv -----
`default_nettype none

package bcpf_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned PixW   = 8;
  localparam int unsigned IndexW = 16;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 1;

  typedef logic [CoordW-1:0]   coord_t;
  typedef logic [PixW-1:0]     pix_t;
  typedef logic [IndexW-1:0]   feat_idx_t;
  typedef logic [MaskW-1:0]    mask_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_QUANTIZE_MODE  = 2'd0;
  localparam cfg_idx_t CFG_SECAM_MODE     = 2'd1;
  localparam cfg_idx_t CFG_BACKGROUND_DET = 2'd2;

  // Low nibble halved: the colour code of a palette byte, 0..7.
  function automatic logic [2:0] secam_code(input pix_t p);
    secam_code = p[3:1];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bcpf_pix_if.sv -----
`default_nettype none

interface bcpf_pix_if import bcpf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_row;
  coord_t pixel_col;
  pix_t   pixel_value;
  pix_t   background_value;

  modport source (output valid, pixel_row, pixel_col, pixel_value, background_value,
                  input ready);
  modport sink   (input valid, pixel_row, pixel_col, pixel_value, background_value,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bcpf_feat_if.sv -----
`default_nettype none

interface bcpf_feat_if import bcpf_pkg::*; ();
  logic      valid;
  logic      ready;
  feat_idx_t feature_index;
  mask_t     feature_value;

  modport source (output valid, feature_index, feature_value, input ready);
  modport sink   (input valid, feature_index, feature_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bcpf_cfg_if.sv -----
`default_nettype none

interface bcpf_cfg_if import bcpf_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/block_colour_presence_features_unit.sv -----
`default_nettype none

// Block colour-presence feature extractor. Pixels stream in on pix_i, one per
// clock, in raster order with their background bytes; results leave on feat_o.
// Each pixel passes through an input register, then a single pass of
// table lookup and mask update into the output register, so one
// pixel is taken every cycle while feat_o is not stalled. In quantize mode the
// screen is cut into BLOCK_ROWS x BLOCK_COLS blocks; each block's colour mask is
// emitted when its bottom-right pixel arrives. Off-screen pixels and pixels
// beyond the last whole block give no result. In raw mode every on-screen pixel
// gives one result. Configuration writes on cfg_i are always taken and must be
// issued only while no pixel is in flight.

`include "assert_macros.svh"

module block_colour_presence_features_unit import bcpf_pkg::*; #(
  parameter int unsigned SCREEN_HEIGHT = 210,
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned BLOCK_ROWS    = 42,
  parameter int unsigned BLOCK_COLS    = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  bcpf_pix_if.sink     pix_i,
  bcpf_feat_if.source  feat_o,
  bcpf_cfg_if.sink     cfg_i
);

  localparam int unsigned BH      = SCREEN_HEIGHT / BLOCK_ROWS;
  localparam int unsigned BW      = SCREEN_WIDTH / BLOCK_COLS;
  localparam bit          BlockOk = (BH != 0) && (BW != 0);
  localparam int unsigned BhSafe  = (BH == 0) ? 1 : BH;
  localparam int unsigned BwSafe  = (BW == 0) ? 1 : BW;
  localparam int unsigned BxW     = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
  localparam int unsigned CmpW    = 12;
  localparam int unsigned TabN    = 1 << CoordW;

  localparam logic [CmpW-1:0] ScreenH  = CmpW'(SCREEN_HEIGHT);
  localparam logic [CmpW-1:0] ScreenW  = CmpW'(SCREEN_WIDTH);
  localparam logic [CmpW-1:0] BlkRows  = CmpW'(BLOCK_ROWS);
  localparam logic [CmpW-1:0] BlkCols  = CmpW'(BLOCK_COLS);
  localparam logic [CmpW-1:0] BhLast   = CmpW'(BhSafe - 1);
  localparam logic [CmpW-1:0] BwLast   = CmpW'(BwSafe - 1);
  localparam feat_idx_t       ScreenWX = IndexW'(SCREEN_WIDTH);
  localparam feat_idx_t       BlkColsX = IndexW'(BLOCK_COLS);

  // Configuration registers
  logic quantize_q, secam_q, bgdet_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantize_q <= 1'b1;
      secam_q    <= 1'b0;
      bgdet_q    <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_QUANTIZE_MODE:  quantize_q <= cfg_i.data[0];
        CFG_SECAM_MODE:     secam_q    <= cfg_i.data[0];
        CFG_BACKGROUND_DET: bgdet_q    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Constant tables: coordinate to block number and offset inside the block
  coord_t row_blk_tab [TabN];
  coord_t row_off_tab [TabN];
  coord_t col_blk_tab [TabN];
  coord_t col_off_tab [TabN];

  for (genvar i = 0; i < TabN; i++) begin : g_tab
    assign row_blk_tab[i] = CoordW'(i / BhSafe);
    assign row_off_tab[i] = CoordW'(i % BhSafe);
    assign col_blk_tab[i] = CoordW'(i / BwSafe);
    assign col_off_tab[i] = CoordW'(i % BwSafe);
  end

  // Input register stage
  logic   s1_valid_q;
  coord_t s1_row_q, s1_col_q;
  pix_t   s1_pix_q, s1_bg_q;
  logic   s1_fire, in_fire;

  logic        out_valid_q;
  feat_idx_t   out_index_q;
  mask_t       out_value_q;
  logic        out_free;

  assign out_free    = !out_valid_q || feat_o.ready;
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign pix_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q <= pix_i.pixel_row;
      s1_col_q <= pix_i.pixel_col;
      s1_pix_q <= pix_i.pixel_value;
      s1_bg_q  <= pix_i.background_value;
    end
  end

  // Single pass: decode position, update the column's mask, form the result
  logic [BLOCK_COLS-1:0][MaskW-1:0] mask_q;

  coord_t         by, bx, dy, dx;
  logic [BxW-1:0] bx_sel;
  logic           on_screen, in_block, blk_start, blk_last, sampled, counted;
  logic           has_result, mask_we;
  mask_t          mask_d;
  feat_idx_t      raw_index, blk_index;
  mask_t          raw_value;

  always_comb begin
    by = row_blk_tab[s1_row_q];
    dy = row_off_tab[s1_row_q];
    bx = col_blk_tab[s1_col_q];
    dx = col_off_tab[s1_col_q];
    bx_sel = bx[BxW-1:0];

    on_screen = ({{(CmpW-CoordW){1'b0}}, s1_row_q} < ScreenH) &&
                ({{(CmpW-CoordW){1'b0}}, s1_col_q} < ScreenW);
    in_block  = BlockOk &&
                ({{(CmpW-CoordW){1'b0}}, by} < BlkRows) &&
                ({{(CmpW-CoordW){1'b0}}, bx} < BlkCols);
    blk_start = (dy == '0) && (dx == '0);
    blk_last  = ({{(CmpW-CoordW){1'b0}}, dy} == BhLast) &&
                ({{(CmpW-CoordW){1'b0}}, dx} == BwLast);
    sampled   = !(dy[0] ^ dx[0] ^ by[0] ^ bx[0]);
    counted   = sampled && (!bgdet_q || (s1_pix_q != s1_bg_q));

    mask_d = blk_start ? '0 : mask_q[bx_sel];
    if (counted) begin
      mask_d = mask_d | (MaskW'(1) << secam_code(s1_pix_q));
    end

    raw_index = IndexW'(s1_row_q) * ScreenWX + IndexW'(s1_col_q);
    blk_index = IndexW'(by) * BlkColsX + IndexW'(bx);
    raw_value = secam_q ? MaskW'(secam_code(s1_pix_q)) : MaskW'(s1_pix_q >> 1);

    has_result = on_screen && (quantize_q ? (in_block && blk_last) : 1'b1);
    mask_we    = on_screen && quantize_q && in_block;
  end

  // A pixel without a result leaves at once; one with a result waits for room.
  assign s1_fire = s1_valid_q && (out_free || !has_result);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (s1_fire && mask_we) begin
      mask_q[bx_sel] <= mask_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_result) begin
      out_index_q <= quantize_q ? blk_index : raw_index;
      out_value_q <= quantize_q ? mask_d : raw_value;
    end
  end

  assign feat_o.valid         = out_valid_q;
  assign feat_o.feature_index = out_index_q;
  assign feat_o.feature_value = out_value_q;

  // Assertions
  `ASSERT_PROP(a_result_from_stage, clk_i, rst_ni,
               $rose(out_valid_q) |-> $past(s1_valid_q))
  `ASSERT_NEVER(a_no_take_when_blocked, clk_i, rst_ni,
                s1_valid_q && !s1_fire && pix_i.ready)
  `ASSERT_PROP(a_mask_only_at_block_end, clk_i, rst_ni,
               ($past(s1_fire) && $past(quantize_q) && $past(has_result))
               |-> ($past(in_block) && $past(blk_last)))
  `ASSERT_NEVER(a_mask_write_raw_mode, clk_i, rst_ni,
                s1_fire && mask_we && !quantize_q)

endmodule

`default_nettype wire

// ----- tb/sv/bcpf_feature_checker.sv -----
module bcpf_feature_checker import bcpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcpf_pix_if         pix_i,
  bcpf_feat_if        feat_i,
  bcpf_cfg_if         cfg_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ScreenH   = 210;
  localparam int unsigned ScreenW   = 160;
  localparam int unsigned BlockRows = 42;
  localparam int unsigned BlockCols = 32;
  localparam int unsigned BlockH    = ScreenH / BlockRows;
  localparam int unsigned BlockW    = ScreenW / BlockCols;

  typedef struct packed {
    feat_idx_t index;
    mask_t     value;
  } feature_t;

  mask_t    column_masks [BlockCols];
  logic     quantize_on;
  logic     secam_on;
  logic     background_on;
  feature_t expected_features [$];
  feature_t oldest;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches_o++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Work out the feature, if any, that one accepted pixel produces.
  function automatic void predict_pixel(input coord_t row, input coord_t col,
                                        input pix_t p, input pix_t bg);
    int unsigned by;
    int unsigned bx;
    int unsigned dy;
    int unsigned dx;
    logic [2:0]  code;
    feature_t    f;
    code = p[3:1];
    if (row >= ScreenH || col >= ScreenW) return;
    if (!quantize_on) begin
      f.index = feat_idx_t'(row * ScreenW + col);
      f.value = secam_on ? mask_t'(code) : mask_t'(p >> 1);
      expected_features.push_back(f);
      return;
    end
    by = row / BlockH;
    bx = col / BlockW;
    if (by >= BlockRows || bx >= BlockCols) return;
    dy = row - by * BlockH;
    dx = col - bx * BlockW;
    // Top-left pixel opens a fresh block in this column slot.
    if (dy == 0 && dx == 0) column_masks[bx] = '0;
    if (((dy + dx + by + bx) & 1) == 0 && (!background_on || p != bg)) begin
      column_masks[bx] = column_masks[bx] | mask_t'(1 << code);
    end
    if (dy == BlockH - 1 && dx == BlockW - 1) begin
      f.index = feat_idx_t'(by * BlockCols + bx);
      f.value = column_masks[bx];
      expected_features.push_back(f);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (column_masks[i]) column_masks[i] = '0;
      quantize_on   = 1'b1;
      secam_on      = 1'b0;
      background_on = 1'b1;
      expected_features.delete();
      pending_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_QUANTIZE_MODE:  quantize_on   = cfg_i.data[0];
          CFG_SECAM_MODE:     secam_on      = cfg_i.data[0];
          CFG_BACKGROUND_DET: background_on = cfg_i.data[0];
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        predict_pixel(pix_i.pixel_row, pix_i.pixel_col, pix_i.pixel_value,
                      pix_i.background_value);
      end
      if (feat_i.valid && feat_i.ready) begin
        if (expected_features.size() == 0) begin
          report_mismatch($sformatf("unexpected feature index %0d value %02h",
                                    feat_i.feature_index, feat_i.feature_value));
        end else begin
          oldest = expected_features.pop_front();
          if (feat_i.feature_index !== oldest.index) begin
            report_mismatch($sformatf("feature_index %0d, want %0d",
                                      feat_i.feature_index, oldest.index));
          end
          if (feat_i.feature_value !== oldest.value) begin
            report_mismatch($sformatf("feature_value %02h, want %02h (index %0d)",
                                      feat_i.feature_value, oldest.value, oldest.index));
          end
        end
      end
      pending_o = expected_features.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bcpf_pkg::*;

  localparam int unsigned ScreenH       = 210;
  localparam int unsigned ScreenW       = 160;
  localparam int unsigned BlockRows     = 42;
  localparam int unsigned BlockCols     = 32;
  localparam int unsigned BlockSide     = 5;
  localparam int unsigned ItemTarget    = 950;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 16;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned pending_features;
  int unsigned mismatches;
  int unsigned pixels_sent   = 0;
  int unsigned src_idle_pct  = 21;
  int unsigned sink_idle_pct = 60;
  int unsigned cycle_count   = 0;
  logic        pressure_req  = 1'b0;
  logic        hold_off      = 1'b0;

  bcpf_pix_if  pixel_stream ();
  bcpf_feat_if feature_stream ();
  bcpf_cfg_if  register_port ();

  always #4 clk_i = ~clk_i;

  block_colour_presence_features_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pixel_stream),
    .feat_o (feature_stream),
    .cfg_i  (register_port)
  );

  bcpf_feature_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pixel_stream),
    .feat_i       (feature_stream),
    .cfg_i        (register_port),
    .pending_o    (pending_features),
    .mismatches_o (mismatches)
  );

  always @(negedge clk_i) begin
    feature_stream.ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
  end

  // Long receiver stall so the block backs up and stalls its input.
  initial begin
    wait (pressure_req);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("block_colour_presence_features_unit verification failed");
      $finish;
    end
  end

  task automatic send_pixel(input int unsigned row, input int unsigned col,
                            input int unsigned pix, input int unsigned bg);
    while ($urandom_range(99) < src_idle_pct) begin
      pixel_stream.valid <= 1'b0;
      @(negedge clk_i);
    end
    pixel_stream.valid            <= 1'b1;
    pixel_stream.pixel_row        <= coord_t'(row);
    pixel_stream.pixel_col        <= coord_t'(col);
    pixel_stream.pixel_value      <= pix_t'(pix);
    pixel_stream.background_value <= pix_t'(bg);
    @(posedge clk_i);
    while (!pixel_stream.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (row < ScreenH && col < ScreenW) pixels_sent++;
    // Swap the idle pattern by thirds, then run without gaps.
    if (pixels_sent >= 2 * ItemTarget / 3) begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end else if (pixels_sent >= ItemTarget / 3) begin
      src_idle_pct  = 60;
      sink_idle_pct = 21;
    end
  endtask

  // Random content; the background matches the pixel about a third of the time.
  task automatic send_scene_pixel(input int unsigned row, input int unsigned col);
    int unsigned pix;
    int unsigned bg;
    pix = $urandom_range(255);
    bg  = ($urandom_range(2) == 0) ? pix : $urandom_range(255);
    send_pixel(row, col, pix, bg);
  endtask

  task automatic send_noise_pixel();
    send_scene_pixel($urandom_range(255), $urandom_range(255));
  endtask

  // Raster scan of one block row over a run of adjacent blocks, optionally dropping pixels.
  task automatic send_block_band(input int unsigned by, input int unsigned bx0,
                                 input int unsigned nblocks, input int unsigned drop_pct);
    for (int unsigned dy = 0; dy < BlockSide; dy++) begin
      for (int unsigned c = bx0 * BlockSide; c < (bx0 + nblocks) * BlockSide; c++) begin
        if ($urandom_range(99) >= drop_pct) send_scene_pixel(by * BlockSide + dy, c);
      end
    end
  endtask

  task automatic run_block_phase(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned nb;
    start = pixels_sent;
    while (pixels_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 90) begin
        nb = $urandom_range(1, 3);
        send_block_band($urandom_range(BlockRows - 1), $urandom_range(BlockCols - nb), nb,
                        (pick < 78) ? 0 : 25);
      end else begin
        repeat ($urandom_range(1, 4)) send_noise_pixel();
      end
    end
  endtask

  task automatic run_raw_phase(input int unsigned budget);
    int unsigned start;
    int unsigned row;
    int unsigned col;
    start = pixels_sent;
    send_pixel(0, 0, 8'h00, 8'h00);
    send_pixel(ScreenH - 1, ScreenW - 1, 8'hFF, 8'hFF);
    while (pixels_sent - start < budget) begin
      row = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(ScreenH - 1);
      col = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(ScreenW - 1);
      send_scene_pixel(row, col);
    end
  endtask

  task automatic write_register(input cfg_idx_t idx, input cfg_data_t data);
    register_port.valid <= 1'b1;
    register_port.index <= idx;
    register_port.data  <= data;
    @(posedge clk_i);
    while (!register_port.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, let every expected feature drain, then let the pipeline settle.
  task automatic wait_idle();
    pixel_stream.valid <= 1'b0;
    while (pending_features != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_mode(input cfg_data_t quantize, input cfg_data_t secam,
                          input cfg_data_t background);
    wait_idle();
    write_register(CFG_QUANTIZE_MODE, quantize);
    write_register(CFG_SECAM_MODE, secam);
    write_register(CFG_BACKGROUND_DET, background);
    register_port.valid <= 1'b0;
  endtask

  initial begin
    pixel_stream.valid            = 1'b0;
    pixel_stream.pixel_row        = '0;
    pixel_stream.pixel_col        = '0;
    pixel_stream.pixel_value      = '0;
    pixel_stream.background_value = '0;
    feature_stream.ready          = 1'b0;
    register_port.valid           = 1'b0;
    register_port.index           = CFG_QUANTIZE_MODE;
    register_port.data            = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: full scan of the bottom-right block, every colour code,
    // background hits on every third pixel but the last, both byte extremes.
    for (int unsigned i = 0; i < BlockSide * BlockSide; i++) begin
      send_pixel((BlockRows - 1) * BlockSide + i / BlockSide,
                 (BlockCols - 1) * BlockSide + i % BlockSide,
                 (i == BlockSide * BlockSide - 1) ? 255 : (i * 37) % 256,
                 (i % 3 == 0) ? (i * 37) % 256 : 8'h5A);
    end
    // Off the screen: no feature, no state change.
    send_pixel(ScreenH, 0, 8'h0F, 8'h00);
    send_pixel(0, ScreenW, 8'h0F, 8'h00);
    send_pixel(255, 255, 8'hFF, 8'h00);

    set_mode(1'b1, 1'b0, 1'b1);
    run_block_phase(300);
    set_mode(1'b0, 1'b0, 1'b1);
    run_raw_phase(75);
    set_mode(1'b1, 1'b1, 1'b0);
    run_block_phase(250);
    set_mode(1'b0, 1'b1, 1'b0);
    pressure_req = 1'b1;
    run_raw_phase(75);
    set_mode(1'b1, 1'b0, 1'b0);
    run_block_phase(250);
    wait_idle();

    if (mismatches == 0) begin
      $display("block_colour_presence_features_unit verification clean");
    end else begin
      $display("block_colour_presence_features_unit verification failed");
    end
    $finish;
  end

endmodule
